/* hw/rtl/ple_pkg.sv */
// Shared types, constants and codes for the positional list engine.
package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_AT    = 3'd2;
    localparam logic [2:0] OP_DEL_FRONT = 3'd3;
    localparam logic [2:0] OP_DEL_BACK  = 3'd4;
    localparam logic [2:0] OP_DEL_AT    = 3'd5;
    localparam logic [2:0] OP_SEARCH    = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADPOS  = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } ple_in_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] result_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         length;
    } ple_out_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [IDX_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         count;
    } ple_cmd_t;

    // Per-cell flags back to the controller.
    typedef struct packed {
        logic match;
        logic sel;
    } ple_flag_t;

endpackage

/* hw/rtl/ple_cell.sv */
// One slot of the list: holds an entry, shifts with its neighbors, compares.
module ple_cell (
    input  logic                             clk,
    input  logic                             en,
    input  logic [ple_pkg::IDX_W-1:0]        idx,
    input  ple_pkg::ple_cmd_t                cmd,
    input  logic signed [ple_pkg::DATA_W-1:0] left,
    input  logic signed [ple_pkg::DATA_W-1:0] right,
    output logic signed [ple_pkg::DATA_W-1:0] entry,
    output ple_pkg::ple_flag_t               flag
);
    import ple_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     live;

    assign live  = CNT_W'(idx) < cmd.count;
    assign entry = entry_reg;
    assign flag.match = live && (entry_reg == cmd.value);
    assign flag.sel   = (idx == cmd.pos);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (idx == cmd.pos)
                entry_next = cmd.value;
            else if (idx > cmd.pos)
                entry_next = left;
        end
        else if (cmd.del)
        begin
            if (idx >= cmd.pos)
                entry_next = right;
        end
    end

    // Payload only; no reset.
    always_ff @(posedge clk)
    begin
        if (en)
            entry_reg <= entry_next;
    end

endmodule

/* hw/rtl/positional_list_engine_core.sv */
// Top level of the positional list engine: command decode, cell chain, result register.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one command item:
//   opcode, value, position. rsp channel (rsp_valid / rsp_stall / rsp)
//   returns exactly one result item per command: status, result_value,
//   found_position and the length after the command.
//   The result is registered: an item accepted at one edge shows its
//   result in the rsp register right after that edge. Throughput is one
//   item per cycle while rsp_stall is low; the whole command, shifting
//   and comparing, is done in one step of the cell chain, every cell
//   moving its entry to or from a neighbor at once. The search priority
//   encode over the cells sets the critical path. When the receiver
//   stalls, the result is held in the rsp register and cmd_stall is
//   raised; a new item is taken in the same cycle the held result leaves.
//   Reset (rst_n low, asynchronous) empties the list and drops rsp_valid.
//   Entry contents are not cleared; only slots below the count are read.
module positional_list_engine_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  ple_pkg::ple_in_t  cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ple_pkg::ple_out_t rsp
);
    import ple_pkg::*;

    logic                     accept;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    ple_out_t                 rsp_reg;
    ple_out_t                 rsp_next;

    ple_cmd_t                 bcast;
    logic signed [DATA_W-1:0] entries [CAPACITY];
    ple_flag_t                flags   [CAPACITY];

    logic [POS_W-1:0]         count_w;
    logic [POS_W-1:0]         tgt;
    logic                     full;
    logic                     empty;
    logic signed [DATA_W-1:0] sel_value;
    logic                     hit;
    logic [IDX_W-1:0]         hit_idx;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign count_w = POS_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    // Slot picked by the delete, and the first live match for a search.
    always_comb
    begin
        sel_value = '0;
        hit       = 1'b0;
        hit_idx   = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (flags[k].sel)
                sel_value = sel_value | entries[k];
            if (flags[k].match)
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(k);
            end
        end
    end

    // Command decode.
    always_comb
    begin
        tgt          = '0;
        bcast.ins    = 1'b0;
        bcast.del    = 1'b0;
        bcast.value  = cmd.value;
        bcast.count  = count_reg;
        count_next   = count_reg;
        rsp_next.status         = ST_OK;
        rsp_next.result_value   = '0;
        rsp_next.found_position = '0;

        case (cmd.opcode)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
            begin
                if (cmd.opcode == OP_INS_FRONT)
                    tgt = '0;
                else if (cmd.opcode == OP_INS_BACK)
                    tgt = count_w;
                else
                    tgt = cmd.position;
                if (tgt > count_w)
                    rsp_next.status = ST_BADPOS;
                else if (full)
                    rsp_next.status = ST_FULL;
                else
                begin
                    bcast.ins  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT:
            begin
                if (cmd.opcode == OP_DEL_FRONT)
                    tgt = '0;
                else if (cmd.opcode == OP_DEL_BACK)
                    tgt = count_w - 1'b1;
                else
                    tgt = cmd.position;
                if (empty)
                    rsp_next.status = ST_EMPTY;
                else if (tgt >= count_w)
                    rsp_next.status = ST_BADPOS;
                else
                begin
                    bcast.del             = 1'b1;
                    count_next            = count_reg - 1'b1;
                    rsp_next.result_value = sel_value;
                end
            end
            OP_SEARCH:
            begin
                if (hit)
                begin
                    rsp_next.result_value   = cmd.value;
                    rsp_next.found_position = POS_W'(hit_idx);
                end
                else
                    rsp_next.status = ST_MISSING;
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase

        bcast.pos       = tgt[IDX_W-1:0];
        rsp_next.length = POS_W'(count_next);
    end

    // Cell chain: each slot sees its left and right neighbor.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_in;
        logic signed [DATA_W-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = cmd.value;
        end
        else
        begin : g_mid_l
            assign left_in = entries[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_in = cmd.value;
        end
        else
        begin : g_mid_r
            assign right_in = entries[g+1];
        end

        ple_cell u_cell (
            .clk   (clk),
            .en    (accept),
            .idx   (IDX_W'(g)),
            .cmd   (bcast),
            .left  (left_in),
            .right (right_in),
            .entry (entries[g]),
            .flag  (flags[g])
        );
    end

    always_comb
    begin
        if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp_stall)
            rsp_valid_next = rsp_valid_reg;
        else
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    // Checks.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_len_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.length == POS_W'(count_reg))
        else $error("reported length differs from held count");

    a_full_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_FULL) |-> count_reg == CNT_W'(CAPACITY))
        else $error("full status while list not full");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && bcast.ins) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list");

endmodule

/* bench/positional_list_engine_core_tb.sv */
// Self-checking testbench for the positional list engine core.
module positional_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    // Unused opcode: the block answers it with ok and no change.
    localparam logic [2:0] OP_NONE = 3'd7;

    // Contents of the list as the bench sees it: slots below count are live.
    typedef struct {
        logic [DATA_W-1:0] slot [CAPACITY];
        int unsigned       count;
    } list_state_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    ple_in_t  cmd = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    ple_out_t rsp;

    ple_in_t     pending_cmd [$];   // items waiting to be offered
    ple_out_t    expected_rsp [$];  // results predicted for accepted items
    list_state_t model_list;        // list state tracked at acceptance
    list_state_t gen_list;          // list state tracked while building stimulus
    int          n_accepted = 0;
    int          errors = 0;
    logic        hold_rsp = 1'b0;   // long receiver hold-off
    logic        calm;              // stretch with no idling on either side

    assign calm = (n_accepted >= 600) && (n_accepted < 800);

    positional_list_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Apply one command to a list and return the result item it produces.
    // Inserts check the position before the full condition; deletes check
    // for an empty list before the position.
    function automatic ple_out_t list_apply(inout list_state_t st, input ple_in_t c);
        ple_out_t    r;
        int unsigned p;
        int unsigned k;
        logic        hit;
        r   = '0;
        p   = 0;
        hit = 1'b0;
        case (c.opcode)
            OP_INS_BACK: p = st.count;
            OP_INS_AT:   p = c.position;
            OP_DEL_BACK: p = (st.count == 0) ? 0 : st.count - 1;
            OP_DEL_AT:   p = c.position;
            default:     p = 0;
        endcase
        r.status = ST_OK;
        case (c.opcode)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
            begin
                if (p > st.count)
                    r.status = ST_BADPOS;
                else if (st.count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (k = st.count; k > p; k--)
                        st.slot[k] = st.slot[k-1];
                    st.slot[p] = c.value;
                    st.count++;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT:
            begin
                if (st.count == 0)
                    r.status = ST_EMPTY;
                else if (p >= st.count)
                    r.status = ST_BADPOS;
                else
                begin
                    r.result_value = st.slot[p];
                    for (k = p; k + 1 < st.count; k++)
                        st.slot[k] = st.slot[k+1];
                    st.count--;
                end
            end
            OP_SEARCH:
            begin
                r.status = ST_MISSING;
                for (k = 0; k < st.count; k++)
                begin
                    if (!hit && st.slot[k] == c.value)
                    begin
                        hit              = 1'b1;
                        r.status         = ST_OK;
                        r.result_value   = c.value;
                        r.found_position = k[POS_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.length = st.count[POS_W-1:0];
        return r;
    endfunction

    // Queue one command and track its effect so later commands can aim
    // at live positions and stored values.
    task automatic queue_cmd(input logic [2:0] op, input logic [DATA_W-1:0] v,
                             input int unsigned p);
        ple_in_t  c;
        c.opcode   = op;
        c.value    = v;
        c.position = p[POS_W-1:0];
        void'(list_apply(gen_list, c));
        pending_cmd.push_back(c);
    endtask

    // Driver: offers pending items, idling at random; a stalled item is held.
    // The prediction is made at the edge where the item is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_rsp.push_back(list_apply(model_list, cmd));
                n_accepted <= n_accepted + 1;
            end
            if (!cmd_valid || !cmd_stall)
            begin
                // keep offering during the hold-off so the block backs up
                if (pending_cmd.size() > 0 &&
                    (calm || hold_rsp || $urandom_range(0, 99) >= 24))
                begin
                    cmd_valid <= 1'b1;
                    cmd       <= pending_cmd.pop_front();
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction
    // and drives the receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        ple_out_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result: status %0d value %0d pos %0d len %0d",
                                 rsp.status, rsp.result_value, rsp.found_position,
                                 rsp.length);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status ||
                        rsp.result_value !== want.result_value ||
                        rsp.found_position !== want.found_position ||
                        rsp.length !== want.length)
                    begin
                        if (errors < 10)
                        begin
                            $write("mismatch: exp status %0d value %0d pos %0d len %0d,",
                                   want.status, want.result_value, want.found_position,
                                   want.length);
                            $display(" got status %0d value %0d pos %0d len %0d",
                                     rsp.status, rsp.result_value,
                                     rsp.found_position, rsp.length);
                        end
                        errors = errors + 1;
                    end
                end
            end
            rsp_stall <= hold_rsp || (!calm && $urandom_range(0, 99) < 24);
        end
    end

    // Long receiver hold-off once traffic is under way.
    initial
    begin
        wait (n_accepted >= 300);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (150) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int          n;
        int          bias;
        int          roll;
        int unsigned cnt;
        int unsigned pos;
        logic [2:0]  op;
        logic [DATA_W-1:0] v;

        model_list.count = 0;
        gen_list.count   = 0;

        // Directed: empty list corners first.
        queue_cmd(OP_SEARCH,    32'd0,          0);
        queue_cmd(OP_DEL_FRONT, 32'd0,          0);
        queue_cmd(OP_DEL_BACK,  32'd0,          0);
        queue_cmd(OP_DEL_AT,    32'd0,          0);   // empty wins over position
        queue_cmd(OP_DEL_AT,    32'hFFFF_FFFF,  255);
        queue_cmd(OP_NONE,      32'hFFFF_FFFF,  255);
        queue_cmd(OP_INS_AT,    32'd1,          1);   // past the end
        // Build a short list with the value extremes.
        queue_cmd(OP_INS_AT,    32'h8000_0000,  0);
        queue_cmd(OP_INS_BACK,  32'h7FFF_FFFF,  0);
        queue_cmd(OP_INS_FRONT, 32'hFFFF_FFFF,  0);
        queue_cmd(OP_INS_AT,    32'd0,          3);   // at count: appends
        queue_cmd(OP_INS_AT,    32'd5,          2);
        queue_cmd(OP_INS_AT,    32'd9,          255);
        queue_cmd(OP_SEARCH,    32'h7FFF_FFFF,  0);
        queue_cmd(OP_SEARCH,    32'd0,          0);
        queue_cmd(OP_SEARCH,    32'd12345,      0);   // miss on a live list
        queue_cmd(OP_INS_FRONT, 32'd5,          0);
        queue_cmd(OP_SEARCH,    32'd5,          0);   // first of two matches
        queue_cmd(OP_DEL_AT,    32'd0,          5);   // last slot
        queue_cmd(OP_DEL_AT,    32'd0,          5);   // now past the end
        queue_cmd(OP_DEL_AT,    32'd0,          255);
        queue_cmd(OP_NONE,      32'd0,          0);
        queue_cmd(OP_DEL_FRONT, 32'd0,          0);
        queue_cmd(OP_DEL_BACK,  32'd0,          0);
        queue_cmd(OP_DEL_AT,    32'd0,          1);

        // Random: phases that grow, shrink or hold the list, so the full
        // and empty corners are both visited many times.
        bias = 0;
        for (n = 0; n < 1050; n++)
        begin
            if (n % 120 == 0)
                bias = $urandom_range(0, 2);
            cnt  = gen_list.count;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = OP_NONE;
            else if ((bias == 0 && roll < 70) || (bias == 1 && roll < 20) ||
                     (bias == 2 && roll < 40))
                op = 3'($urandom_range(OP_INS_FRONT, OP_INS_AT));
            else if ((bias == 0 && roll < 88) || (bias == 1 && roll < 88) ||
                     (bias == 2 && roll < 78))
                op = 3'($urandom_range(OP_DEL_FRONT, OP_DEL_AT));
            else
                op = OP_SEARCH;

            // Position: mostly live, sometimes anywhere in the field.
            if ($urandom_range(0, 99) < 15)
                pos = $urandom_range(0, 255);
            else if (op == OP_INS_AT)
                pos = $urandom_range(0, cnt);
            else
                pos = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);

            // Value: full range, a small set to make duplicates, extremes.
            roll = $urandom_range(0, 99);
            if (roll < 55)
                v = $urandom;
            else if (roll < 90)
                v = $urandom_range(0, 7);
            else if (roll < 95)
                v = 32'h8000_0000;
            else
                v = 32'h7FFF_FFFF;
            if (op == OP_SEARCH && cnt > 0 && $urandom_range(0, 99) < 70)
                v = gen_list.slot[$urandom_range(0, cnt - 1)];

            queue_cmd(op, v, pos);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmd.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
